FILE: hw/rtl/piecewise_linear_interpolator_top_defines.svh
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator_top_defines
// Assertion macros for the interpolator checker.
// ---------------------------------------------------------------------------
`ifndef PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH
`define PIECEWISE_LINEAR_INTERPOLATOR_TOP_DEFINES_SVH

// property checked outside reset
`define PLI_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// property checked on every edge, reset included
`define PLI_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

FILE: hw/rtl/pli_pkg.sv
// ---------------------------------------------------------------------------
// pli_pkg
// Types and constants of the piecewise linear interpolator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package pli_pkg;

    localparam int PLI_VW         = 32;  // Q16.16 value width
    localparam int PLI_IW         = 6;   // point_index width
    localparam int PLI_PW         = 7;   // points_in_use width
    localparam int PLI_MAX_POINTS = 64;

    localparam logic ACT_LOAD  = 1'b0;
    localparam logic ACT_QUERY = 1'b1;

    typedef struct packed {
        logic                     action;
        logic [PLI_IW-1:0]        point_index;
        logic signed [PLI_VW-1:0] x_value;
        logic signed [PLI_VW-1:0] y_value;
    } t_in;

    typedef struct packed {
        logic                     result_valid;
        logic signed [PLI_VW-1:0] y_result;
    } t_out;

endpackage

FILE: hw/rtl/pli_cell.sv
// ---------------------------------------------------------------------------
// pli_cell
// One breakpoint slot of the ring; loads directly or takes its neighbour.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_cell (
    input  logic                          i_clk,
    input  logic                          i_shift,
    input  logic                          i_load,
    input  logic [pli_pkg::PLI_VW-1:0]    i_x,
    input  logic [pli_pkg::PLI_VW-1:0]    i_y,
    input  logic [pli_pkg::PLI_VW-1:0]    i_nx,
    input  logic [pli_pkg::PLI_VW-1:0]    i_ny,
    output logic [pli_pkg::PLI_VW-1:0]    o_x,
    output logic [pli_pkg::PLI_VW-1:0]    o_y
);
    import pli_pkg::*;

    logic [PLI_VW-1:0] r_x;
    logic [PLI_VW-1:0] r_y;

    always_ff @(posedge i_clk) begin
        if (i_shift) begin
            r_x <= i_nx;
            r_y <= i_ny;
        end else if (i_load) begin
            r_x <= i_x;
            r_y <= i_y;
        end
    end

    assign o_x = r_x;
    assign o_y = r_y;

endmodule

FILE: hw/rtl/pli_div.sv
// ---------------------------------------------------------------------------
// pli_div
// Bit-serial scaled quotient floor(mag * t / d), one mag bit per cycle.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module pli_div (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [pli_pkg::PLI_VW:0]    i_mag,
    input  logic [pli_pkg::PLI_VW-1:0]  i_t,
    input  logic [pli_pkg::PLI_VW-1:0]  i_d,
    output logic                        o_busy,
    output logic [pli_pkg::PLI_VW:0]    o_q
);
    import pli_pkg::*;

    localparam int CNTW = $clog2(PLI_VW + 1);

    logic              r_busy;
    logic [CNTW-1:0]   r_cnt;
    logic [PLI_VW:0]   r_mag;
    logic [PLI_VW-1:0] r_t;
    logic [PLI_VW-1:0] r_d;
    logic [PLI_VW-1:0] r_r;
    logic [PLI_VW:0]   r_q;

    logic [PLI_VW+1:0]        w_s;
    logic signed [PLI_VW+2:0] w_s1;
    logic signed [PLI_VW+2:0] w_s2;
    logic [PLI_VW-1:0]        n_r;
    logic [1:0]               n_c;

    always_comb begin
        w_s  = {1'b0, r_r, 1'b0} + (r_mag[PLI_VW] ? {2'b00, r_t} : '0);
        w_s1 = $signed({1'b0, w_s}) - $signed({3'b000, r_d});
        w_s2 = $signed({1'b0, w_s}) - $signed({2'b00, r_d, 1'b0});
        if (!w_s2[PLI_VW+2]) begin
            n_r = w_s2[PLI_VW-1:0];
            n_c = 2'd2;
        end else if (!w_s1[PLI_VW+2]) begin
            n_r = w_s1[PLI_VW-1:0];
            n_c = 2'd1;
        end else begin
            n_r = w_s[PLI_VW-1:0];
            n_c = 2'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= CNTW'(PLI_VW);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNTW'(1);
            if (r_cnt == '0) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mag <= i_mag;
            r_t   <= i_t;
            r_d   <= i_d;
            r_r   <= '0;
            r_q   <= '0;
        end else if (r_busy) begin
            r_mag <= {r_mag[PLI_VW-1:0], 1'b0};
            r_r   <= n_r;
            r_q   <= {r_q[PLI_VW-1:0], 1'b0} + {{(PLI_VW-1){1'b0}}, n_c};
        end
    end

    assign o_busy = r_busy;
    assign o_q    = r_q;

endmodule

FILE: hw/rtl/piecewise_linear_interpolator_top.sv
// ---------------------------------------------------------------------------
// piecewise_linear_interpolator_top
// Breakpoint table with linear interpolation between bracketing points.
// ---------------------------------------------------------------------------
// Use: input beats (i_valid / o_ready) carry t_in. A load beat writes one
// breakpoint (x, y) and gives no output beat. A query beat scans segments
// (k, k+1) in order and yields one output beat (o_valid / i_ready) of
// t_out: the first bracketing segment interpolated, or result_valid = 0
// with y_result = 0.
// Breakpoints sit in a ring of MAX_POINTS cells. A query rotates the ring
// once, one step a cycle, so the segment under test is always at cells 0
// and 1; when the rotation ends the table is back in place. The divider
// (one quotient bit a cycle) starts as soon as the segment is found and
// runs alongside the rest of the rotation.
// A query holds o_ready low: the block takes no new beat until the ring
// rotation and, for a late segment, the divider are done and the result
// is in the output register. Loads are taken while the block is idle.
// points_in_use (i_cfg_we / i_cfg_wdata) resets to 2; values above
// MAX_POINTS act as MAX_POINTS. The table itself is not cleared by reset.
// A stalled output beat is held in the output register; loads are still
// taken meanwhile, a finished query waits until that register is free.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module piecewise_linear_interpolator_top #(
    parameter int MAX_POINTS = pli_pkg::PLI_MAX_POINTS
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    output logic                           o_ready,
    input  pli_pkg::t_in                   i_item,
    output logic                           o_valid,
    input  logic                           i_ready,
    output pli_pkg::t_out                  o_result,
    input  logic                           i_cfg_we,
    input  logic [pli_pkg::PLI_PW-1:0]     i_cfg_wdata
);
    import pli_pkg::*;

    localparam int SW = $clog2(MAX_POINTS);
    localparam int CW = (SW + 1 > PLI_PW) ? SW + 1 : PLI_PW;

    typedef enum logic [1:0] {S_IDLE, S_SCAN, S_WAIT} t_state;

    t_state                   r_state, n_state;
    logic [SW-1:0]            r_step, n_step;
    logic signed [PLI_VW-1:0] r_xq, n_xq;
    logic                     r_found, n_found;
    logic                     r_eq, n_eq;
    logic                     r_neg, n_neg;
    logic signed [PLI_VW-1:0] r_y0, n_y0;
    logic                     r_out_valid, n_out_valid;
    t_out                     r_out, n_out;
    logic [PLI_PW-1:0]        r_points;

    logic [PLI_VW-1:0] w_x [MAX_POINTS];
    logic [PLI_VW-1:0] w_y [MAX_POINTS];
    logic              w_shift;
    logic              w_acc_load;

    // segment test at the head of the ring
    logic [CW-1:0]            w_nlim;
    logic                     w_active;
    logic                     w_hit;
    logic signed [PLI_VW:0]   w_d;
    logic signed [PLI_VW:0]   w_t;
    logic signed [PLI_VW:0]   w_dy;
    logic [PLI_VW:0]          w_mag;
    logic                     w_start;
    logic                     w_busy;
    logic [PLI_VW:0]          w_q;
    logic signed [PLI_VW+1:0] w_sum;

    assign o_ready    = (r_state == S_IDLE);
    assign w_acc_load = i_valid && o_ready && (i_item.action == ACT_LOAD);
    assign w_shift    = (r_state == S_SCAN);

    for (genvar i = 0; i < MAX_POINTS; i++) begin : g_cell
        localparam int NB = (i + 1) % MAX_POINTS;
        logic w_ld;
        if (i < (1 << PLI_IW)) begin : g_ld
            assign w_ld = w_acc_load && (i_item.point_index == PLI_IW'(i));
        end else begin : g_nold
            assign w_ld = 1'b0;
        end
        pli_cell u_cell (
            .i_clk   (i_clk),
            .i_shift (w_shift),
            .i_load  (w_ld),
            .i_x     (i_item.x_value),
            .i_y     (i_item.y_value),
            .i_nx    (w_x[NB]),
            .i_ny    (w_y[NB]),
            .o_x     (w_x[i]),
            .o_y     (w_y[i])
        );
    end

    always_comb begin
        w_nlim   = (CW'(r_points) > CW'(MAX_POINTS)) ? CW'(MAX_POINTS) : CW'(r_points);
        w_active = (CW'(r_step) + CW'(1)) < w_nlim;
        w_hit    = ($signed(w_x[0]) <= r_xq) && ($signed(w_x[1]) >= r_xq);
        w_d      = $signed({w_x[1][PLI_VW-1], w_x[1]}) - $signed({w_x[0][PLI_VW-1], w_x[0]});
        w_t      = $signed({r_xq[PLI_VW-1], r_xq}) - $signed({w_x[0][PLI_VW-1], w_x[0]});
        w_dy     = $signed({w_y[1][PLI_VW-1], w_y[1]}) - $signed({w_y[0][PLI_VW-1], w_y[0]});
        w_mag    = w_dy[PLI_VW] ? $unsigned(-w_dy) : $unsigned(w_dy);
        w_start  = (r_state == S_SCAN) && !r_found && w_active && w_hit
                   && (w_d != '0);
        w_sum    = r_neg ? $signed({{2{r_y0[PLI_VW-1]}}, r_y0}) - $signed({1'b0, w_q})
                         : $signed({{2{r_y0[PLI_VW-1]}}, r_y0}) + $signed({1'b0, w_q});
    end

    pli_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_mag   (w_mag),
        .i_t     (w_t[PLI_VW-1:0]),
        .i_d     (w_d[PLI_VW-1:0]),
        .o_busy  (w_busy),
        .o_q     (w_q)
    );

    always_comb begin
        n_state     = r_state;
        n_step      = r_step;
        n_xq        = r_xq;
        n_found     = r_found;
        n_eq        = r_eq;
        n_neg       = r_neg;
        n_y0        = r_y0;
        n_out       = r_out;
        n_out_valid = r_out_valid && !i_ready;
        case (r_state)
            S_IDLE: begin
                if (i_valid && i_item.action == ACT_QUERY) begin
                    n_xq    = i_item.x_value;
                    n_step  = '0;
                    n_found = 1'b0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_found && w_active && w_hit) begin
                    n_found = 1'b1;
                    n_eq    = (w_d == '0);
                    n_neg   = w_dy[PLI_VW];
                    n_y0    = $signed(w_y[0]);
                end
                n_step = r_step + SW'(1);
                if (r_step == SW'(MAX_POINTS - 1)) begin
                    n_state = S_WAIT;
                end
            end
            S_WAIT: begin
                if (!w_busy && (!r_out_valid || i_ready)) begin
                    n_out_valid        = 1'b1;
                    n_out.result_valid = r_found;
                    if (!r_found) begin
                        n_out.y_result = '0;
                    end else if (r_eq) begin
                        n_out.y_result = r_y0;
                    end else if (w_sum > $signed({2'b00, {(PLI_VW-1){1'b1}}})) begin
                        n_out.y_result = {1'b0, {(PLI_VW-1){1'b1}}};
                    end else if (w_sum < $signed({3'b111, {(PLI_VW-1){1'b0}}})) begin
                        n_out.y_result = {1'b1, {(PLI_VW-1){1'b0}}};
                    end else begin
                        n_out.y_result = w_sum[PLI_VW-1:0];
                    end
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
            r_found     <= 1'b0;
            r_points    <= PLI_PW'(2);
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_found     <= n_found;
            if (i_cfg_we) begin
                r_points <= i_cfg_wdata;
            end
        end
        r_step <= n_step;
        r_xq   <= n_xq;
        r_eq   <= n_eq;
        r_neg  <= n_neg;
        r_y0   <= n_y0;
        r_out  <= n_out;
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

FILE: hw/rtl/pli_chk.sv
// ---------------------------------------------------------------------------
// pli_chk
// Port-level checks of the interpolator, bound to the top level.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "piecewise_linear_interpolator_top_defines.svh"

module pli_chk (
    input logic          i_clk,
    input logic          i_rst_n,
    input logic          i_valid,
    input logic          o_ready,
    input pli_pkg::t_in  i_item,
    input logic          o_valid,
    input logic          i_ready,
    input pli_pkg::t_out o_result
);
    import pli_pkg::*;

    // stalled output beat holds
    `PLI_ASSERT(a_out_hold, o_valid && !i_ready |=> o_valid && $stable(o_result), "output beat changed while stalled")

    // a miss always carries a zero value
    `PLI_ASSERT(a_miss_zero, o_valid && !o_result.result_valid |-> o_result.y_result == '0, "miss with nonzero y")

    // a query beat takes the block busy
    `PLI_ASSERT(a_query_busy, i_valid && o_ready && i_item.action == ACT_QUERY |=> !o_ready, "ready after query beat")

    // no output beat straight out of reset
    `PLI_ASSERT_ALWAYS(a_rst_quiet, !i_rst_n |=> !o_valid, "output valid after reset")

endmodule

bind piecewise_linear_interpolator_top pli_chk u_pli_chk (.*);

FILE: verif/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking bench for the piecewise linear interpolator.
// ---------------------------------------------------------------------------
// Fills the whole breakpoint table once, so that no query ever reads an
// unwritten slot. It then walks a short table of directed beats: extreme
// endpoints, steep negative slopes, equal-x segments and out-of-range
// queries. After that come random phases. Each phase sets points_in_use,
// loads a sorted breakpoint set with random content and fires queries,
// mixed with noise loads. Every query beat is predicted at acceptance by a
// local interpolation model and queued. Output beats are checked in order,
// field by field.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;
    import pli_pkg::*;

    localparam int  NPTS      = PLI_MAX_POINTS;
    localparam int  QUIET_MAX = 5000;  // cycles with no beat on either side
    localparam int  DRAIN_CYC = 100;   // idle gap before a register write and at the end
    localparam longint VMAX   = 64'sd2147483647;
    localparam longint VMIN   = -64'sd2147483648;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_valid = 1'b0;
    logic                 o_ready;
    t_in                  i_item = '0;
    logic                 o_valid;
    logic                 i_ready = 1'b0;
    t_out                 o_result;
    logic                 i_cfg_we = 1'b0;
    logic [PLI_PW-1:0]    i_cfg_wdata = '0;

    // interpolation model state
    longint               bp_x [NPTS];
    longint               bp_y [NPTS];
    int                   n_search = 2;
    t_out                 pending_y [$];

    int                   errors = 0;
    int                   quiet = 0;
    int                   idle_pct = 0;   // sender gaps, in percent
    int                   stall_pct = 0;  // receiver stalls, per hundred
    bit                   hold_off = 1'b0;

    typedef struct {
        t_in  beat;
        bit   known;
        t_out want;
    } t_row;

    piecewise_linear_interpolator_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_item      (i_item),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_result    (o_result),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #4 i_clk = ~i_clk;

    function automatic longint clamp32(longint v);
        if (v > VMAX) return VMAX;
        if (v < VMIN) return VMIN;
        return v;
    endfunction

    // y0 + sign(dy) * trunc(|dy| * t / d), clamped to 32 bits, product kept exact in 128 bits
    function automatic longint lerp_seg(int k, longint x);
        longint x0, x1, y0, y1, dy;
        logic [127:0] mag, num, q;
        x0 = bp_x[k];
        x1 = bp_x[k+1];
        y0 = bp_y[k];
        y1 = bp_y[k+1];
        if (x0 == x1) return y0;
        dy  = y1 - y0;
        mag = (dy < 0) ? 128'(-dy) : 128'(dy);
        num = mag * 128'(x - x0);
        q   = num / 128'(x1 - x0);
        return clamp32((dy < 0) ? y0 - longint'(q) : y0 + longint'(q));
    endfunction

    // applies a beat to the model; returns 1 when it yields an output beat
    function automatic bit model_beat(t_in b, output t_out r);
        int n;
        longint x;
        r = '0;
        x = longint'(b.x_value);
        if (b.action == ACT_LOAD) begin
            bp_x[b.point_index] = x;
            bp_y[b.point_index] = longint'(b.y_value);
            return 1'b0;
        end
        n = (n_search > NPTS) ? NPTS : n_search;
        for (int k = 0; k + 1 < n; k++) begin
            if (bp_x[k] <= x && bp_x[k+1] >= x) begin
                r.result_valid = 1'b1;
                r.y_result     = 32'(lerp_seg(k, x));
                break;
            end
        end
        return 1'b1;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("%0t mismatch %s: got %0d, expected %0d", $time, what, got, want);
        errors++;
    endtask

    // offer one beat, hold it until taken, then predict it
    task automatic send_beat(t_in b, bit known = 1'b0, t_out want = '0);
        t_out r;
        while ($urandom_range(99) < idle_pct) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid = 1'b1;
        i_item  = b;
        do @(posedge i_clk); while (!o_ready);
        if (model_beat(b, r)) begin
            if (known && r != want)
                report_mismatch("directed table entry", r.y_result, want.y_result);
            pending_y.insert(pending_y.size(), r);
        end
        @(negedge i_clk);
    endtask

    function automatic t_in mk(logic act, int idx, longint x, longint y);
        t_in b;
        b.action      = act;
        b.point_index = PLI_IW'(idx);
        b.x_value     = 32'(x);
        b.y_value     = 32'(y);
        return b;
    endfunction

    // register write only with the block idle
    task automatic set_points(int v);
        i_valid = 1'b0;
        wait (pending_y.size() == 0);
        repeat (DRAIN_CYC) @(negedge i_clk);
        i_cfg_we    = 1'b1;
        i_cfg_wdata = PLI_PW'(v);
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        n_search = v;
    endtask

    // receiver: random stalls, or a long hold-off while the sender runs on
    always @(negedge i_clk)
        i_ready <= !hold_off && ($urandom_range(99) >= stall_pct);

    // output checker and watchdog
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if ((i_valid && o_ready) || (o_valid && i_ready))
                quiet <= 0;
            else
                quiet <= quiet + 1;
            if (quiet >= QUIET_MAX) begin
                $display("tb_top: FAIL");
                $finish;
            end
            if (o_valid && i_ready) begin
                if (pending_y.size() == 0) begin
                    report_mismatch("unexpected output beat", o_result.y_result, 0);
                end else begin
                    if (o_result.result_valid != pending_y[0].result_valid)
                        report_mismatch("result_valid", o_result.result_valid,
                                        pending_y[0].result_valid);
                    if (o_result.y_result != pending_y[0].y_result)
                        report_mismatch("y_result", o_result.y_result,
                                        pending_y[0].y_result);
                    void'(pending_y.pop_front());
                end
            end
        end
    end

    initial begin
        t_row   rows [$];
        longint xs [$];
        longint x, y, d;
        int     n, k, ph;
        int     cfgs [8] = '{64, 2, 0, 1, 127, 37, 16, 0};

        repeat (4) @(negedge i_clk);
        i_rst_n = 1'b1;

        // every slot written before any query can read it
        for (int i = 0; i < NPTS; i++)
            send_beat(mk(ACT_LOAD, i, VMIN + longint'(i) * 33554432, $urandom));

        // directed beats, points_in_use still at its reset value of 2
        rows = '{
            '{mk(ACT_LOAD, 0, VMIN, VMIN), 0, '0},
            '{mk(ACT_LOAD, 1, VMAX, VMAX), 0, '0},
            '{mk(ACT_QUERY, 63, VMIN, VMAX), 1, '{1'b1, 32'(VMIN)}},
            '{mk(ACT_QUERY, 0, VMAX, 0), 1, '{1'b1, 32'(VMAX)}},
            '{mk(ACT_QUERY, 21, 0, -1), 0, '0},
            '{mk(ACT_QUERY, 42, -1, 1), 0, '0},
            '{mk(ACT_LOAD, 0, VMIN, VMAX), 0, '0},
            '{mk(ACT_LOAD, 1, VMAX, VMIN), 0, '0},
            '{mk(ACT_QUERY, 0, 0, 0), 0, '0},
            '{mk(ACT_QUERY, 0, 1, 0), 0, '0},
            '{mk(ACT_QUERY, 0, VMAX - 1, 0), 0, '0},
            // equal x in a segment: first point's y
            '{mk(ACT_LOAD, 0, 5, 7), 0, '0},
            '{mk(ACT_LOAD, 1, 5, 99), 0, '0},
            '{mk(ACT_QUERY, 0, 5, 0), 1, '{1'b1, 32'sd7}},
            // outside the only segment
            '{mk(ACT_QUERY, 0, 6, 0), 1, '{1'b0, 32'sd0}},
            '{mk(ACT_QUERY, 0, 4, 0), 1, '{1'b0, 32'sd0}},
            '{mk(ACT_LOAD, 0, -65536, 32'sh0001_8000), 0, '0},
            '{mk(ACT_LOAD, 1, 65536, -65536), 0, '0},
            '{mk(ACT_QUERY, 0, 0, 0), 0, '0},
            '{mk(ACT_QUERY, 0, 32768, 0), 0, '0},
            '{mk(ACT_QUERY, 0, VMIN, 0), 1, '{1'b0, 32'sd0}}
        };
        foreach (rows[i])
            send_beat(rows[i].beat, rows[i].known, rows[i].want);

        for (ph = 0; ph < 8; ph++) begin
            set_points((ph == 7) ? $urandom_range(2, 127) : cfgs[ph]);
            case (ph % 4)
                0: begin idle_pct = 0;  stall_pct = 0;  end
                1: begin idle_pct = 47; stall_pct = 0;  end
                2: begin idle_pct = 0;  stall_pct = 47; end
                default: begin idle_pct = 24; stall_pct = 24; end
            endcase

            // long receiver hold-off: the output register fills, input stalls
            if (ph == 4)
                fork
                    begin
                        hold_off = 1'b1;
                        repeat (600) @(negedge i_clk);
                        hold_off = 1'b0;
                    end
                join_none

            // sorted breakpoint set, with the odd repeated x
            n = (n_search > NPTS) ? NPTS : (n_search < 2 ? 2 : n_search);
            xs.delete();
            for (int i = 0; i < n; i++)
                xs.insert(xs.size(), longint'($signed($urandom)));
            xs.sort();
            for (int i = 1; i < n; i++)
                if ($urandom_range(7) == 0) xs[i] = xs[i-1];
            for (int i = 0; i < n; i++)
                send_beat(mk(ACT_LOAD, i, xs[i], longint'($signed($urandom))));

            for (int q = 0; q < 16; q++) begin
                k = $urandom_range(n - 2);
                d = xs[k+1] - xs[k];
                x = xs[k] + ((d == 0) ? 0 : longint'({$urandom, $urandom} % (d + 1)));
                if ($urandom_range(9) == 0) x = longint'($signed($urandom));
                send_beat(mk(ACT_QUERY, $urandom_range(63), x, $urandom));
                // noise: a stray load that may break the ordering
                if ($urandom_range(15) == 0) begin
                    y = longint'($signed($urandom));
                    send_beat(mk(ACT_LOAD, $urandom_range(63), longint'($signed($urandom)), y));
                end
            end
        end

        i_valid = 1'b0;
        wait (pending_y.size() == 0);
        repeat (DRAIN_CYC) @(negedge i_clk);
        if (errors == 0)
            $display("tb_top: PASS");
        else
            $display("tb_top: FAIL");
        $finish;
    end
endmodule

FILE: sim.f
+incdir+hw/rtl
hw/rtl/pli_pkg.sv
hw/rtl/pli_cell.sv
hw/rtl/pli_div.sv
hw/rtl/piecewise_linear_interpolator_top.sv
hw/rtl/pli_chk.sv
verif/tb_top.sv
